/* src/rttp_pkg.sv */
// Shared types and constants for the ringtone text note parser.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rttp_pkg;
   // Phase codes of the character parser
   localparam logic [3:0] PH_NAME   = 4'd0;
   localparam logic [3:0] PH_DKEY   = 4'd1;
   localparam logic [3:0] PH_DSEP   = 4'd2;
   localparam logic [3:0] PH_DEQ    = 4'd3;
   localparam logic [3:0] PH_DVAL   = 4'd4;
   localparam logic [3:0] PH_NSTART = 4'd5;
   localparam logic [3:0] PH_NDUR   = 4'd6;
   localparam logic [3:0] PH_MOD0   = 4'd7;

   localparam int MS_NUM      = 60000;
   localparam int DIVD_BITS   = 24;   // dur*60000, dur <= 72
   localparam int DIVS_BITS   = 19;   // tempo*8

   // One completed note, passed from front to back
   typedef struct packed {
      logic [4:0]  note_n_q;     // octave index n/12, clipped
      logic [3:0]  semi;         // n mod 12
      logic        pause;
      logic [7:0]  dur;          // thirty-seconds
      logic [15:0] tempo;
      logic        final_res;
   } note_type;

   function automatic logic [12:0] top_tone(input logic [3:0] s);
      case (s)
         4'd0:  top_tone = 13'd4186;
         4'd1:  top_tone = 13'd4434;
         4'd2:  top_tone = 13'd4698;
         4'd3:  top_tone = 13'd4978;
         4'd4:  top_tone = 13'd5274;
         4'd5:  top_tone = 13'd5587;
         4'd6:  top_tone = 13'd5919;
         4'd7:  top_tone = 13'd6271;
         4'd8:  top_tone = 13'd6644;
         4'd9:  top_tone = 13'd7040;
         4'd10: top_tone = 13'd7458;
         4'd11: top_tone = 13'd7902;
         default: top_tone = 13'd0;
      endcase
   endfunction
endpackage
`default_nettype wire

/* src/rttp_front.sv */
// Character parser: phases, defaults and note assembly; pushes completed notes.
// Depends on rttp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rttp_front #(
   parameter int NUMBER_BITS = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_stall,
   input  wire logic [7:0]       ch,
   input  wire logic             last,
   output logic                  push,
   output rttp_pkg::note_type    push_note,
   input  wire logic             q_full
);
   import rttp_pkg::*;

   localparam logic [NUMBER_BITS-1:0] ACC_MAX = '1;

   logic [3:0]             phase_ff, phase_in;
   logic [7:0]             ddur_ff, ddur_in;
   logic [3:0]             doct_ff, doct_in;
   logic [15:0]            tempo_ff, tempo_in;
   logic [NUMBER_BITS-1:0] acc_ff, acc_in;
   logic [7:0]             key_ff, key_in;
   logic signed [5:0]      nidx_ff, nidx_in;
   logic [3:0]             noct_ff, noct_in;
   logic [7:0]             ndur_ff, ndur_in;
   logic                   abort_ff, abort_in;

   logic       take, emit, emit_now, emit_late;
   logic       isdig;
   logic [3:0] dig;
   logic [NUMBER_BITS+3:0] acc_next;
   logic [NUMBER_BITS-1:0] acc_sat;
   logic [7:0] dur_acc;
   logic [3:0] s;
   logic signed [5:0] sel_idx;
   logic [3:0]        sel_oct;

   assign in_stall = q_full;
   assign take     = in_valid && !q_full;
   assign isdig    = (ch >= 8'h30) && (ch <= 8'h39);
   assign dig      = ch[3:0];
   assign acc_next = ({4'd0, acc_ff} << 3) + ({4'd0, acc_ff} << 1) + {{NUMBER_BITS{1'b0}}, dig};
   assign acc_sat  = (acc_next > {4'd0, ACC_MAX}) ? ACC_MAX : acc_next[NUMBER_BITS-1:0];
   assign s        = phase_ff - PH_MOD0;

   // 32 / acc for the few values where it is non-zero
   always_comb begin
      if (acc_ff <= 1)       dur_acc = 8'd32;
      else if (acc_ff == 2)  dur_acc = 8'd16;
      else if (acc_ff <= 32) begin
         case (acc_ff[5:0])
            6'd3: dur_acc = 8'd10; 6'd4: dur_acc = 8'd8; 6'd5: dur_acc = 8'd6;
            6'd6: dur_acc = 8'd5;  6'd7: dur_acc = 8'd4; 6'd8: dur_acc = 8'd4;
            6'd9, 6'd10: dur_acc = 8'd3;
            6'd11, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16: dur_acc = 8'd2;
            default: dur_acc = 8'd1;
         endcase
      end else dur_acc = 8'd0;
   end

   function automatic logic signed [5:0] letter_idx(input logic [7:0] c);
      case (c)
         "C", "c": letter_idx = 6'sd0;
         "D", "d": letter_idx = 6'sd2;
         "E", "e": letter_idx = 6'sd4;
         "F", "f": letter_idx = 6'sd5;
         "G", "g": letter_idx = 6'sd7;
         "A", "a": letter_idx = 6'sd9;
         "B", "b", "H", "h": letter_idx = 6'sd11;
         default: letter_idx = -6'sd1;
      endcase
   endfunction

   always_comb begin
      phase_in = phase_ff; ddur_in = ddur_ff; doct_in = doct_ff; tempo_in = tempo_ff;
      acc_in = acc_ff; key_in = key_ff; nidx_in = nidx_ff; noct_in = noct_ff;
      ndur_in = ndur_ff; abort_in = abort_ff; emit_now = 1'b0; emit_late = 1'b0;
      if (!abort_ff) begin
         if (ch == 8'd0) begin
            emit_now = (phase_ff >= PH_MOD0);
            abort_in = 1'b1;
         end else begin
            case (phase_ff)
               PH_NAME: if (ch == ":") phase_in = PH_DKEY;
               PH_DKEY, PH_DSEP: begin
                  if (phase_ff == PH_DSEP && ch == ",") phase_in = PH_DKEY;
                  else if (ch != " ") begin
                     if (ch == ":") phase_in = PH_NSTART;
                     else begin key_in = ch; phase_in = PH_DEQ; end
                  end
               end
               PH_DEQ: begin
                  if (ch == "=") begin acc_in = '0; phase_in = PH_DVAL; end
                  else abort_in = 1'b1;
               end
               PH_DVAL: begin
                  if (isdig) acc_in = acc_sat;
                  else begin
                     if (key_ff == "d") ddur_in = dur_acc;
                     else if (key_ff == "o") doct_in = (acc_ff > 15) ? 4'd15 : 4'(acc_ff);
                     else if (key_ff == "b")
                        tempo_in = (acc_ff == 0) ? 16'd1 :
                                   ((32'(acc_ff) > 65535) ? 16'hFFFF : 16'(acc_ff));
                     if (ch == " ") phase_in = PH_DSEP;
                     else if (ch == ",") phase_in = PH_DKEY;
                     else if (ch == ":") phase_in = PH_NSTART;
                     else begin key_in = ch; phase_in = PH_DEQ; end
                  end
               end
               PH_NSTART: begin
                  if (ch != " ") begin
                     if (isdig) begin acc_in = NUMBER_BITS'(dig); phase_in = PH_NDUR; end
                     else begin
                        nidx_in = letter_idx(ch); noct_in = doct_ff;
                        ndur_in = ddur_ff; phase_in = PH_MOD0;
                     end
                  end
               end
               PH_NDUR: begin
                  if (isdig) acc_in = acc_sat;
                  else begin
                     nidx_in = letter_idx(ch); noct_in = doct_ff;
                     ndur_in = dur_acc; phase_in = PH_MOD0;
                  end
               end
               default: begin
                  if (ch == "#" && s == 0) begin
                     nidx_in = nidx_ff + 6'sd1; phase_in = PH_MOD0 + 4'd1;
                  end else if (ch == "b" && s <= 1) begin
                     nidx_in = nidx_ff - 6'sd1; phase_in = PH_MOD0 + 4'd2;
                  end else if (ch == "." && s <= 4) begin
                     ndur_in = ndur_ff + {1'b0, ndur_ff[7:1]};
                     phase_in = PH_MOD0 + ((s <= 2) ? 4'd3 : 4'd5);
                  end else if (isdig && s <= 3) begin
                     noct_in = dig; phase_in = PH_MOD0 + 4'd4;
                  end else if (ch == " ") begin
                     phase_in = PH_MOD0 + 4'd5;
                  end else begin
                     emit_now = 1'b1;
                     phase_in = PH_NSTART;
                     if (ch != ",") begin
                        if (isdig) begin acc_in = NUMBER_BITS'(dig); phase_in = PH_NDUR; end
                        else begin
                           nidx_in = letter_idx(ch); noct_in = doct_ff;
                           ndur_in = ddur_ff; phase_in = PH_MOD0;
                        end
                     end
                  end
               end
            endcase
         end
         // final character flushes a still-open note, with this character applied
         emit_late = last && !emit_now && !abort_in && (phase_in >= PH_MOD0);
      end
   end

   assign emit = emit_now || emit_late;

   // note word: a closed note comes from the current registers, a flushed one
   // from the updated values; octave and semitone are split without a divide
   always_comb begin
      sel_idx = emit_late ? nidx_in : nidx_ff;
      sel_oct = emit_late ? noct_in : noct_ff;
      push_note.pause = (sel_idx == -6'sd1);
      if (sel_idx < 6'sd0) begin
         push_note.semi     = 4'(sel_idx + 6'sd12);
         push_note.note_n_q = {1'b0, sel_oct};
      end else if (sel_idx > 6'sd11) begin
         push_note.semi     = 4'(sel_idx - 6'sd12);
         push_note.note_n_q = {1'b0, sel_oct} + 5'd2;
      end else begin
         push_note.semi     = sel_idx[3:0];
         push_note.note_n_q = {1'b0, sel_oct} + 5'd1;
      end
      push_note.dur       = emit_late ? ndur_in : ndur_ff;
      push_note.tempo     = tempo_ff;
      push_note.final_res = last || abort_in;
   end

   assign push = take && emit;

   always_ff @(posedge clock) begin
      if (reset || (take && last)) begin
         phase_ff <= PH_NAME; ddur_ff <= 8'd8; doct_ff <= 4'd6; tempo_ff <= 16'd63;
         acc_ff <= '0; key_ff <= 8'd0; nidx_ff <= -6'sd1; noct_ff <= 4'd6;
         ndur_ff <= 8'd8; abort_ff <= 1'b0;
      end else if (take) begin
         phase_ff <= phase_in; ddur_ff <= ddur_in; doct_ff <= doct_in; tempo_ff <= tempo_in;
         acc_ff <= acc_in; key_ff <= key_in; nidx_ff <= nidx_in; noct_ff <= noct_in;
         ndur_ff <= ndur_in; abort_ff <= abort_in;
      end
   end
endmodule
`default_nettype wire

/* src/rttp_back.sv */
// Note queue and timing back end: serial divider for note time, tone lookup.
// Depends on rttp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rttp_back (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  rttp_pkg::note_type push_note,
   output logic               q_full,
   output logic               out_valid,
   input  wire logic          out_stall,
   output logic [12:0]        tone_hz,
   output logic [19:0]        on_ms,
   output logic [16:0]        off_ms,
   output logic               final_res
);
   import rttp_pkg::*;

   // two-entry queue
   note_type   q_ff [2];
   logic [1:0] cnt_ff;
   logic       rd_ff, wr_ff;
   logic       pop;

   // divider
   logic        busy_ff;
   logic [4:0]  step_ff;
   logic [DIVD_BITS-1:0] rem_ff, quo_ff;
   logic [DIVS_BITS-1:0] dvs_ff;
   note_type    cur_ff;
   logic [DIVD_BITS:0] trial;
   logic [DIVD_BITS-1:0] quo_fin;

   assign q_full = (cnt_ff == 2'd2);
   assign pop    = (cnt_ff != 0) && !busy_ff && (!out_valid || !out_stall);

   assign trial   = {rem_ff, quo_ff[DIVD_BITS-1]} - {6'd0, dvs_ff};
   assign quo_fin = {quo_ff[DIVD_BITS-2:0], !trial[DIVD_BITS]};

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ff] <= push_note;
      if (reset) begin
         cnt_ff <= '0; rd_ff <= 1'b0; wr_ff <= 1'b0;
      end else begin
         if (push) wr_ff <= !wr_ff;
         if (pop)  rd_ff <= !rd_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

   logic finish;
   assign finish = busy_ff && (step_ff == 5'(DIVD_BITS - 1)) && (!out_valid || !out_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; out_valid <= 1'b0;
      end else begin
         out_valid <= finish || (out_valid && out_stall);
         if (pop) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
            cur_ff  <= q_ff[rd_ff];
            dvs_ff  <= {q_ff[rd_ff].tempo, 3'd0};
            rem_ff  <= '0;
            quo_ff  <= 24'(q_ff[rd_ff].dur) * 24'(MS_NUM);
         end else if (busy_ff && step_ff != 5'(DIVD_BITS - 1)) begin
            step_ff <= step_ff + 5'd1;
            if (!trial[DIVD_BITS]) rem_ff <= trial[DIVD_BITS-1:0];
            else rem_ff <= {rem_ff[DIVD_BITS-2:0], quo_ff[DIVD_BITS-1]};
            quo_ff <= {quo_ff[DIVD_BITS-2:0], !trial[DIVD_BITS]};
         end else if (finish) begin
            busy_ff   <= 1'b0;
            final_res <= cur_ff.final_res;
            if (cur_ff.pause) begin
               tone_hz <= '0;
               on_ms   <= quo_fin[19:0];
               off_ms  <= '0;
            end else begin
               tone_hz <= top_tone(cur_ff.semi) >> ((cur_ff.note_n_q > 9) ? 4'd0 :
                          4'(5'd9 - cur_ff.note_n_q));
               on_ms   <= 20'(({8'd0, quo_fin} * 32'd7) >> 3);
               off_ms  <= quo_fin[19:3];
            end
         end
      end
   end
endmodule
`default_nettype wire

/* src/ringtone_text_note_parser_core.sv */
// Ringtone text note parser top level: character front end plus note timing back end.
// Depends on rttp_pkg, rttp_front, rttp_back.
`timescale 1ns / 1ps
`default_nettype none
// Takes one song character per transfer (req_ch, req_last) and gives one transfer per
// completed note: frequency, sounding time, gap and a final flag. Characters are taken
// one per cycle unless stalled; each note then passes through the serial divider of the
// back end. The parser keeps taking characters meanwhile and stalls only when the two-entry
// note queue is full, whether or not the current character closes a note.
module ringtone_text_note_parser_core #(
   parameter int NUMBER_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_ch,
   input  wire logic        req_last,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [12:0]      rsp_tone_hz,
   output logic [19:0]      rsp_on_ms,
   output logic [16:0]      rsp_off_ms,
   output logic             rsp_final_res
);
   import rttp_pkg::*;

   logic     push, q_full;
   note_type push_note;

   rttp_front #(.NUMBER_BITS(NUMBER_BITS)) u_front (
      .clock, .reset, .in_valid(req_valid), .in_stall(req_stall),
      .ch(req_ch), .last(req_last), .push, .push_note, .q_full
   );

   rttp_back u_back (
      .clock, .reset, .push, .push_note, .q_full,
      .out_valid(rsp_valid), .out_stall(rsp_stall),
      .tone_hz(rsp_tone_hz), .on_ms(rsp_on_ms), .off_ms(rsp_off_ms),
      .final_res(rsp_final_res)
   );
endmodule
`default_nettype wire

/* tb/sv/rttp_checker.sv */
// Checker for the ringtone text note parser: watches both channels, predicts notes.
// Depends on rttp_pkg for the phase codes.
`timescale 1ns / 1ps
module rttp_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [7:0]  req_ch,
   input  wire logic        req_last,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [12:0] rsp_tone_hz,
   input  wire logic [19:0] rsp_on_ms,
   input  wire logic [16:0] rsp_off_ms,
   input  wire logic        rsp_final_res,
   output int               fail_count,
   output int               pending_notes,
   output int               notes_seen
);
   import rttp_pkg::*;

   localparam int NUM_BITS = 16;

   typedef struct packed {
      logic [12:0] tone_hz;
      logic [19:0] on_ms;
      logic [16:0] off_ms;
      logic        final_res;
   } note_res_t;

   note_res_t note_q[$];

   logic [3:0]  ph;
   int unsigned def_dur, def_oct, bpm, acc, key, n_oct, n_dur;
   int          n_idx;
   bit          ended;

   function automatic int unsigned base_tone(int unsigned s);
      case (s)
         0: return 4186;  1: return 4434;  2: return 4698;  3: return 4978;
         4: return 5274;  5: return 5587;  6: return 5919;  7: return 6271;
         8: return 6644;  9: return 7040;  10: return 7458; default: return 7902;
      endcase
   endfunction

   function automatic bit is_dig(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic int letter_idx(logic [7:0] c);
      case (c)
         "C", "c": return 0;
         "D", "d": return 2;
         "E", "e": return 4;
         "F", "f": return 5;
         "G", "g": return 7;
         "A", "a": return 9;
         "B", "b", "H", "h": return 11;
         default: return -1;
      endcase
   endfunction

   task automatic clear_song();
      ph = PH_NAME; def_dur = 8; def_oct = 6; bpm = 63; acc = 0; key = 0;
      n_idx = -1; n_oct = 6; n_dur = 8; ended = 0;
   endtask

   task automatic add_digit(logic [7:0] c);
      longint unsigned v;
      v = longint'(acc) * 10 + (c - "0");
      acc = (v > (2 ** NUM_BITS - 1)) ? (2 ** NUM_BITS - 1) : v;
   endtask

   function automatic note_res_t timed_note();
      note_res_t r;
      longint unsigned ms;
      int unsigned n, q, sh;
      ms = (longint'(n_dur) * 60000) / (longint'(bpm) * 8);
      ms = ms & 32'hFFFF_FFFF;
      if (n_idx == -1) begin
         r.tone_hz = 0; r.on_ms = ms[19:0]; r.off_ms = 0;
      end else begin
         n = n_oct * 12 + 12 + n_idx;
         q = n / 12;
         sh = q > 9 ? 0 : 9 - q;
         r.tone_hz = base_tone(n % 12) >> sh;
         r.on_ms = ((ms * 7) & 32'hFFFF_FFFF) / 8;
         r.off_ms = ms / 8;
      end
      r.final_res = 0;
      return r;
   endfunction

   task automatic key_or_colon(logic [7:0] c);
      if (c == ":") ph = PH_NSTART;
      else begin
         key = c; ph = PH_DEQ;
      end
   endtask

   task automatic start_note(logic [7:0] c, int unsigned d);
      n_idx = letter_idx(c); n_oct = def_oct; n_dur = d; ph = PH_MOD0;
   endtask

   task automatic note_first(logic [7:0] c);
      if (is_dig(c)) begin
         acc = c - "0"; ph = PH_NDUR;
      end else start_note(c, def_dur);
   endtask

   task automatic parse_char(logic [7:0] c, logic lst);
      note_res_t r;
      bit got;
      int unsigned s;
      got = 0;
      if (!ended) begin
         if (c == 0) begin
            if (ph >= PH_MOD0) begin
               r = timed_note(); got = 1;
            end
            ended = 1;
         end else if (ph == PH_NAME) begin
            if (c == ":") ph = PH_DKEY;
         end else if (ph == PH_DKEY) begin
            if (c != " ") key_or_colon(c);
         end else if (ph == PH_DSEP) begin
            if (c == ",") ph = PH_DKEY;
            else if (c != " ") key_or_colon(c);
         end else if (ph == PH_DEQ) begin
            if (c == "=") begin
               acc = 0; ph = PH_DVAL;
            end else ended = 1;
         end else if (ph == PH_DVAL) begin
            if (is_dig(c)) add_digit(c);
            else begin
               if (key == "d") def_dur = 32 / (acc == 0 ? 1 : acc);
               else if (key == "o") def_oct = acc > 15 ? 15 : acc;
               else if (key == "b") bpm = acc == 0 ? 1 : (acc > 65535 ? 65535 : acc);
               if (c == " ") ph = PH_DSEP;
               else if (c == ",") ph = PH_DKEY;
               else key_or_colon(c);
            end
         end else if (ph == PH_NSTART) begin
            if (c != " ") note_first(c);
         end else if (ph == PH_NDUR) begin
            if (is_dig(c)) add_digit(c);
            else start_note(c, 32 / (acc == 0 ? 1 : acc));
         end else begin
            s = ph - PH_MOD0;
            if (c == "#" && s == 0) begin
               n_idx++; ph = PH_MOD0 + 1;
            end else if (c == "b" && s <= 1) begin
               n_idx--; ph = PH_MOD0 + 2;
            end else if (c == "." && s <= 4) begin
               n_dur += n_dur / 2;
               ph = PH_MOD0 + (s <= 2 ? 3 : 5);
            end else if (is_dig(c) && s <= 3) begin
               n_oct = c - "0"; ph = PH_MOD0 + 4;
            end else if (c == " ") begin
               ph = PH_MOD0 + 5;
            end else begin
               r = timed_note(); got = 1;
               ph = PH_NSTART;
               if (c != ",") note_first(c);
            end
         end
         if (lst && !got && !ended && ph >= PH_MOD0) begin
            r = timed_note(); got = 1;
         end
         if (got) begin
            if (lst || ended) r.final_res = 1;
            note_q.push_back(r);
         end
      end
      if (lst) clear_song();
   endtask

   note_res_t got_r, exp_r;

   always @(posedge clock) begin
      if (reset) begin
         clear_song();
         note_q.delete();
         fail_count <= 0;
         notes_seen <= 0;
      end else begin
         if (req_valid && !req_stall) parse_char(req_ch, req_last);
         if (rsp_valid && !rsp_stall) begin
            notes_seen <= notes_seen + 1;
            got_r = '{rsp_tone_hz, rsp_on_ms, rsp_off_ms, rsp_final_res};
            if (note_q.size() == 0) begin
               if (fail_count < 10) $display("unexpected note transfer %p", got_r);
               fail_count <= fail_count + 1;
            end else begin
               exp_r = note_q.pop_front();
               if (got_r !== exp_r) begin
                  if (fail_count < 10)
                     $display("note mismatch: expected %p, got %p", exp_r, got_r);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending_notes = note_q.size();
   end
endmodule

/* tb/sv/ringtone_text_note_parser_core_tb.sv */
// Testbench top for the ringtone text note parser: builds song text and gives the verdict.
// Depends on ringtone_text_note_parser_core and rttp_checker.
`timescale 1ns / 1ps
module ringtone_text_note_parser_core_tb;
   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [7:0]  req_ch = 0;
   logic        req_last = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [12:0] rsp_tone_hz;
   logic [19:0] rsp_on_ms;
   logic [16:0] rsp_off_ms;
   logic        rsp_final_res;
   int          fail_count, pending_notes, notes_seen;
   int          cycle_count = 0;
   int          chars_sent = 0;
   bit          calm = 0;   // no idling on either side while set

   localparam int CYCLE_LIMIT = 400000;

   always #5 clock = ~clock;

   ringtone_text_note_parser_core dut (
      .clock, .reset, .req_valid, .req_stall, .req_ch, .req_last,
      .rsp_valid, .rsp_stall, .rsp_tone_hz, .rsp_on_ms, .rsp_off_ms, .rsp_final_res
   );

   rttp_checker chk (
      .clock, .reset, .req_valid, .req_stall, .req_ch, .req_last,
      .rsp_valid, .rsp_stall, .rsp_tone_hz, .rsp_on_ms, .rsp_off_ms, .rsp_final_res,
      .fail_count, .pending_notes, .notes_seen
   );

   // Receiver stalls at random, except in the calm stretch.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      rsp_stall <= !calm && ($urandom_range(99) < 9);
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("ringtone_text_note_parser_core_tb failed");
         $finish;
      end
   end

   // One character transfer; random idle cycles ahead of it.
   task automatic send_char(logic [7:0] c, logic lst);
      while (!calm && $urandom_range(99) < 9) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1; req_ch <= c; req_last <= lst;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      chars_sent++;
   endtask

   task automatic send_text(string s, bit lst_at_end);
      for (int i = 0; i < s.len(); i++) send_char(s[i], lst_at_end && i == s.len() - 1);
   endtask

   function automatic string rand_num(int maxdig);
      string s;
      int n;
      s = "";
      n = $urandom_range(maxdig, 1);
      for (int i = 0; i < n; i++) s = {s, string'(8'("0" + $urandom_range(9)))};
      return s;
   endfunction

   // Random well-formed note with random optional parts.
   function automatic string rand_note();
      string s;
      byte letters[16] = '{"c","d","e","f","g","a","b","h","p","C","D","E","G","A","B","x"};
      s = "";
      if ($urandom_range(1)) s = rand_num($urandom_range(9) == 0 ? 6 : 2);
      s = {s, string'(letters[$urandom_range(15)])};
      if ($urandom_range(3) == 0) s = {s, "#"};
      if ($urandom_range(5) == 0) s = {s, "b"};
      if ($urandom_range(4) == 0) s = {s, "."};
      if ($urandom_range(1)) s = {s, string'(8'("0" + $urandom_range(9)))};
      if ($urandom_range(4) == 0) s = {s, "."};
      if ($urandom_range(3) == 0) s = {s, " "};
      return s;
   endfunction

   task automatic rand_song();
      string s;
      int n;
      byte c;
      s = $urandom_range(1) ? "tune:" : "x:";
      if ($urandom_range(9) < 8) begin
         if ($urandom_range(1)) s = {s, "d=", rand_num(3), ","};
         if ($urandom_range(1)) s = {s, "o=", rand_num(2), ","};
         if ($urandom_range(1)) s = {s, "b=", rand_num($urandom_range(7) == 0 ? 6 : 3)};
         if ($urandom_range(5) == 0) s = {s, " q=7"};
      end else if ($urandom_range(1)) s = {s, "dz"};
      s = {s, ":"};
      n = $urandom_range(8, 1);
      for (int i = 0; i < n; i++) begin
         s = {s, rand_note()};
         if (i < n - 1 || $urandom_range(1)) s = {s, ","};
      end
      send_text(s, 0);
      // Final character: noise, NUL, a letter, or a digit.
      case ($urandom_range(4))
         0: c = 8'($urandom_range(255));
         1: c = 0;
         2: c = "g";
         default: c = "5";
      endcase
      send_char(c, 1);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // Directed songs: defaults, extremes, flats, dots, pauses and endings.
      send_text("n:d=4,o=5,b=120:c,d#,eb.,8f6.,p,32a#7,h,cb,1g.,", 1);
      send_text("z:d=0,o=99,b=0,k=3:0c9,99999999d", 1);
      send_text("m:b=9999999 ,o=0:4c0", 0);
      send_char(0, 0);
      send_text("zz", 1);
      send_text("bad:d4,c", 1);
      send_text("y::a a", 1);
      send_char(8'hFF, 1);
      // Pause until all notes have come back.
      req_valid <= 0;
      @(posedge clock);
      while (pending_notes != 0) @(posedge clock);
      calm = 1;
      repeat (10) rand_song();
      calm = 0;
      while (chars_sent < 1550) rand_song();
      req_valid <= 0;
      @(posedge clock);
      while (pending_notes != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("sent %0d song characters, checked %0d note transfers", chars_sent, notes_seen);
      if (fail_count == 0 && pending_notes == 0)
         $display("ringtone_text_note_parser_core_tb passed");
      else
         $display("ringtone_text_note_parser_core_tb failed");
      $finish;
   end
endmodule
